### rtl/sync_frame_attitude_parser_top_assert.svh
// Assertion macros for the sync frame attitude parser.
// Used by sync_frame_attitude_parser_top; expects clk and rst_n in scope.
`ifndef SYNC_FRAME_ATTITUDE_PARSER_TOP_ASSERT_SVH
`define SYNC_FRAME_ATTITUDE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SFAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfap assertion failed");

// Next-cycle implication, checked out of reset.
`define SFAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfap assertion failed");

`else

`define SFAP_ASSERT_SAME(label, ante, cons)
`define SFAP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/sfap_pkg.sv
// Shared constants and types for the sync frame attitude parser.
// No dependencies.
package sfap_pkg;

    localparam int POS_W = 4;
    localparam int IDX_W = 3;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // frame positions (index of the next frame byte)
    localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC2    = 4'd1;
    localparam logic [POS_W-1:0] POS_SUM_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd5;
    localparam logic [POS_W-1:0] POS_PAY_LAST = 4'd10;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd11;
    localparam logic [POS_W-1:0] FRAME_LEN    = 4'd12;

    localparam int PAYLOAD_LEN = 6;

    typedef struct packed {
        logic               good;
        logic        [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } sfap_result_t;

endpackage

### rtl/sfap_core.sv
// Frame tracking state: position, running checksum and payload bytes.
// Depends on sfap_pkg.
module sfap_core
    import sfap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output logic         emit,
    output sfap_result_t result
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       payload_reg [PAYLOAD_LEN];
    logic             pay_wr;
    logic [IDX_W-1:0] pay_idx;

    assign pay_idx = IDX_W'(pos_reg - POS_PAYLOAD);
    assign pay_wr  = step && (pos_reg >= POS_PAYLOAD) && (pos_reg <= POS_PAY_LAST);

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        emit     = 1'b0;
        if (pos_reg == POS_HUNT || pos_reg >= FRAME_LEN)
        begin
            pos_next = (rx_byte == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
        end
        else if (pos_reg == POS_SYNC2)
        begin
            // anything but the second sync byte drops back to hunting
            if (rx_byte == SYNC_SECOND)
            begin
                pos_next = POS_SUM_FIRST;
                sum_next = 8'd0;
            end
            else
            begin
                pos_next = POS_HUNT;
            end
        end
        else if (pos_reg < POS_CHECK)
        begin
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + 4'd1;
        end
        else
        begin
            emit     = 1'b1;
            pos_next = POS_HUNT;
            sum_next = 8'd0;
        end
    end

    always_comb
    begin
        result.good = (sum_reg == rx_byte);
        if (result.good)
        begin
            result.yaw   = {payload_reg[1], payload_reg[0]};
            result.pitch = signed'({payload_reg[3], payload_reg[2]});
            result.roll  = signed'({payload_reg[5], payload_reg[4]});
        end
        else
        begin
            result.yaw   = 16'd0;
            result.pitch = 16'sd0;
            result.roll  = 16'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'd0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_wr)
        begin
            payload_reg[pay_idx] <= rx_byte;
        end
    end

endmodule

### rtl/sync_frame_attitude_parser_top.sv
// Sync frame attitude parser: one received byte per transaction, one result per frame.
// res_valid is registered: it rises when checksum byte 11, held in the input register, steps the frame state.
// Throughput: one byte per cycle while no result stalls, set by the input register feeding the frame state.
// The input register holds a byte while a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears valid flags, frame position and sum.
// Depends on sfap_pkg, sfap_core and sync_frame_attitude_parser_top_assert.svh.
`include "sync_frame_attitude_parser_top_assert.svh"

module sync_frame_attitude_parser_top
    import sfap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               frame_good,
    output logic [15:0]        yaw_centideg,
    output logic signed [15:0] pitch_centideg,
    output logic signed [15:0] roll_centideg
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         res_valid_reg;
    logic         res_valid_next;
    sfap_result_t res_reg;
    logic         step;
    logic         emit;
    sfap_result_t result;

    // advance the held byte only when the output register can take a result
    assign step     = in_valid_reg && (!res_valid_reg || res_ready);
    assign rx_ready = !in_valid_reg || step;

    sfap_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    always_comb
    begin
        if (step && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            res_reg <= result;
        end
    end

    assign res_valid      = res_valid_reg;
    assign frame_good     = res_reg.good;
    assign yaw_centideg   = res_reg.yaw;
    assign pitch_centideg = res_reg.pitch;
    assign roll_centideg  = res_reg.roll;

    `SFAP_ASSERT_SAME(a_bad_frame_zero, res_valid && !frame_good, yaw_centideg == 16'd0 && pitch_centideg == 16'sd0 && roll_centideg == 16'sd0)
    `SFAP_ASSERT_SAME(a_stall_blocks_input, in_valid_reg && res_valid_reg && !res_ready, !rx_ready)
    `SFAP_ASSERT_NEXT(a_emit_loads_result, step && emit, res_valid)

endmodule
